[hw/rtl/serial_port_clock_and_control_setup_defines.svh]
// Assertion macros for the serial port clock setup block.
`ifndef SERIAL_PORT_CLOCK_AND_CONTROL_SETUP_DEFINES_SVH
`define SERIAL_PORT_CLOCK_AND_CONTROL_SETUP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SPC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/spcs_pkg.sv]
`default_nettype none
package spcs_pkg;
  localparam int unsigned MAX_HALF_PRESCALE = 127;
  localparam int unsigned MAX_SERIAL_RATE = 256;
  localparam int unsigned NUM_W = 35;
  localparam int unsigned DEN_W = 33;

  typedef enum logic [2:0] {
    ST_IDLE, ST_HALF_DIV, ST_SHIFT, ST_SEARCH, ST_CAND_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_half;
    logic shift;
    logic start_cand;
    logic update;
    logic slave_step;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic need_shift;
    logic search_more;
    logic master_mode;
    logic zero_baud;
    logic half_zero;
  } status_t;

  function automatic logic [1:0] pclk_code(input logic [1:0] plog);
    logic [1:0] c;
    case (plog)
      2'd0: c = 2'd1;
      2'd1: c = 2'd2;
      2'd2: c = 2'd0;
      default: c = 2'd3;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/spcs_divider.sv]
`default_nettype none
`include "serial_port_clock_and_control_setup_defines.svh"
module spcs_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [spcs_pkg::NUM_W-1:0] num,
  input  wire logic [spcs_pkg::DEN_W-1:0] den,
  output logic busy,
  output logic [spcs_pkg::NUM_W-1:0] quo,
  output logic [spcs_pkg::DEN_W:0] rem
);
  localparam int unsigned CW = $clog2(spcs_pkg::NUM_W + 1);
  logic [CW-1:0] count;
  logic [spcs_pkg::DEN_W-1:0] d;
  logic [spcs_pkg::DEN_W+1:0] trial;

  assign trial = {rem, quo[spcs_pkg::NUM_W-1]} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CW'(spcs_pkg::NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      d <= den;
    end else if (busy) begin
      if (!trial[spcs_pkg::DEN_W+1]) begin
        rem <= trial[spcs_pkg::DEN_W:0];
        quo <= {quo[spcs_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[spcs_pkg::DEN_W-1:0], quo[spcs_pkg::NUM_W-1]};
        quo <= {quo[spcs_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  `SPC_ASSERT_NEXT(a_busy_start, clk, rst, start, busy)
  `SPC_ASSERT_IMPL(a_no_restart, clk, rst, busy && count != CW'(1), !start)
  `SPC_ASSERT_IMPL(a_count_ok, clk, rst, busy, count != '0)
endmodule
`default_nettype wire

[hw/rtl/spcs_datapath.sv]
`default_nettype none
module spcs_datapath #(
  parameter int unsigned MAX_HALF_PRESCALE = spcs_pkg::MAX_HALF_PRESCALE,
  parameter int unsigned MAX_SERIAL_RATE = spcs_pkg::MAX_SERIAL_RATE
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire spcs_pkg::cmd_t cmd,
  output spcs_pkg::status_t status,
  input  wire logic [31:0] core_clock_hz,
  input  wire logic [31:0] baud_hz,
  input  wire logic [1:0] frame_protocol,
  input  wire logic [4:0] frame_bits,
  input  wire logic clock_idle_high,
  input  wire logic capture_falling,
  input  wire logic loop_back,
  input  wire logic [1:0] port_mode,
  output logic [15:0] control_word0,
  output logic [3:0] control_word1,
  output logic [7:0] prescale_word,
  output logic [1:0] pclk_select_code,
  output logic [1:0] pclk_divide_log,
  output logic clock_error
);
  localparam int unsigned NW = spcs_pkg::NUM_W;
  localparam logic [NW-1:0] LIMIT = NW'(MAX_SERIAL_RATE * MAX_HALF_PRESCALE);
  localparam logic [NW-1:0] MAXQ = NW'(MAX_SERIAL_RATE);

  logic [31:0] cclk, baud;
  logic [1:0] proto, mode;
  logic [4:0] bits;
  logic idle_hi, fall, loop;
  logic [NW-1:0] half, best_q, best_err;
  logic [7:0] cand, best_c;
  logic [1:0] plog;
  logic err, master, half_phase;
  logic div_busy;
  logic [NW-1:0] quo;
  logic [spcs_pkg::DEN_W:0] rem;
  logic [NW-1:0] div_num;
  logic [spcs_pkg::DEN_W-1:0] div_den;
  logic [35:0] need;
  logic [31:0] shifted;

  assign master = !(mode == 2'd1 || mode == 2'd2);
  assign need = {4'b0, baud} * 36'd12;
  assign shifted = cclk >> plog;

  always_comb begin
    if (cmd.start_half) begin
      div_num = NW'({1'b0, cclk} + {1'b0, baud});
      div_den = {baud, 1'b0};
    end else begin
      div_num = half;
      div_den = spcs_pkg::DEN_W'(cand + 8'd1);
    end
  end

  spcs_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.start_half || cmd.start_cand),
    .num(div_num), .den(div_den), .busy(div_busy), .quo(quo), .rem(rem)
  );

  assign status.div_busy = div_busy;
  assign status.need_shift = ((!half[0]) || half > LIMIT) && plog != 2'd3;
  assign status.search_more = best_err != '0 && cand < 8'(MAX_HALF_PRESCALE);
  assign status.master_mode = master;
  assign status.zero_baud = baud == '0;
  assign status.half_zero = quo == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cclk <= core_clock_hz; baud <= baud_hz; proto <= frame_protocol;
      bits <= frame_bits; idle_hi <= clock_idle_high; fall <= capture_falling;
      loop <= loop_back; mode <= port_mode; plog <= port_mode == 2'd1 ||
        port_mode == 2'd2 ? 2'd3 : 2'd0;
      err <= 1'b0; best_q <= NW'(1); best_c <= 8'd1; best_err <= '0;
      half_phase <= 1'b0;
    end else begin
      if (cmd.start_half) half_phase <= 1'b1;
      if (cmd.start_cand) cand <= cand + 8'd1;
      if (half_phase && !div_busy && !cmd.start_half) begin
        half_phase <= 1'b0;
        half <= quo;
        cand <= 8'd1;
        best_c <= 8'd1;
        if (quo == '0) err <= 1'b1;
      end
      if (cmd.shift) begin
        half <= half >> 1;
        plog <= plog + 2'd1;
      end
      if (cmd.update) begin
        if (cand == 8'd1) begin
          if (half > MAXQ) begin
            best_err <= half; best_q <= MAXQ;
          end else begin
            best_err <= '0; best_q <= half;
          end
        end else if (NW'(rem) < best_err && quo <= MAXQ) begin
          best_err <= NW'(rem); best_q <= quo; best_c <= cand;
        end
      end
      if (cmd.slave_step && !master) begin
        if ({4'b0, shifted} < need) begin
          if (plog != 2'd0) plog <= plog - 2'd1;
          else err <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [7:0] rate;
    logic [7:0] hi;
    rate = 8'(best_q - NW'(1));
    hi = 8'h00;
    if (proto == 2'd1) hi = 8'h10;
    else if (proto == 2'd2) hi = 8'h20;
    else if (idle_hi) hi = fall ? 8'h40 : 8'hc0;
    else if (fall) hi = 8'h80;
    if (!master || baud == '0 || err) rate = 8'd0;
    control_word0 = {rate, hi[7:4], 4'(bits - 5'd1)};
    control_word1 = {mode == 2'd2, mode == 2'd1 || mode == 2'd2, 1'b1, loop};
    prescale_word = (master && baud != '0 && !err) ? {best_c[6:0], 1'b0} : 8'd2;
    pclk_divide_log = (baud == '0) ? 2'd0 : plog;
    pclk_select_code = spcs_pkg::pclk_code(pclk_divide_log);
    clock_error = err && baud != '0;
  end
endmodule
`default_nettype wire

[hw/rtl/spcs_ctrl.sv]
`default_nettype none
`include "serial_port_clock_and_control_setup_defines.svh"
module spcs_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_beat,
  input  wire logic out_beat,
  input  wire spcs_pkg::status_t status,
  output spcs_pkg::cmd_t cmd,
  output logic busy,
  output logic done
);
  spcs_pkg::state_t state, state_next;
  logic [2:0] slave_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spcs_pkg::ST_IDLE;
      slave_cnt <= '0;
    end else begin
      state <= state_next;
      if (in_beat) slave_cnt <= '0;
      else if (cmd.slave_step) slave_cnt <= slave_cnt + 3'd1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      spcs_pkg::ST_IDLE:
        if (in_beat) state_next = spcs_pkg::ST_HALF_DIV;
      spcs_pkg::ST_HALF_DIV: begin
        if (status.zero_baud) state_next = spcs_pkg::ST_DONE;
        else if (!status.master_mode) begin
          if (slave_cnt == 3'd4) state_next = spcs_pkg::ST_DONE;
        end else if (!status.div_busy && slave_cnt == 3'd1) begin
          state_next = status.half_zero ? spcs_pkg::ST_DONE : spcs_pkg::ST_SHIFT;
        end
      end
      spcs_pkg::ST_SHIFT:
        if (!status.need_shift) state_next = spcs_pkg::ST_SEARCH;
      spcs_pkg::ST_SEARCH:
        if (!status.search_more) state_next = spcs_pkg::ST_DONE;
        else state_next = spcs_pkg::ST_CAND_DIV;
      spcs_pkg::ST_CAND_DIV:
        if (!status.div_busy && slave_cnt == 3'd2) state_next = spcs_pkg::ST_SEARCH;
      spcs_pkg::ST_DONE:
        if (out_beat) state_next = spcs_pkg::ST_IDLE;
      default: state_next = spcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_beat;
    case (state)
      spcs_pkg::ST_HALF_DIV: begin
        cmd.start_half = status.master_mode && !status.zero_baud && slave_cnt == 3'd0;
        cmd.slave_step = (!status.master_mode && !status.zero_baud && slave_cnt < 3'd4) ||
          cmd.start_half;
      end
      spcs_pkg::ST_SHIFT: begin
        cmd.shift = status.need_shift;
        cmd.update = !status.need_shift;
      end
      spcs_pkg::ST_SEARCH: begin
        cmd.start_cand = status.search_more;
      end
      spcs_pkg::ST_CAND_DIV: begin
        cmd.slave_step = slave_cnt == 3'd1 && !status.div_busy;
        cmd.update = !status.div_busy && slave_cnt == 3'd2;
      end
      default: cmd.load = in_beat;
    endcase
  end

  assign busy = state != spcs_pkg::ST_IDLE;
  assign done = state == spcs_pkg::ST_DONE;

  `SPC_ASSERT_IMPL(a_load_idle, clk, rst, in_beat, state == spcs_pkg::ST_IDLE)
  `SPC_ASSERT_IMPL(a_out_done, clk, rst, out_beat, done)
  `SPC_ASSERT_NEXT(a_out_idle, clk, rst, out_beat, state == spcs_pkg::ST_IDLE)
endmodule
`default_nettype wire

[hw/rtl/serial_port_clock_and_control_setup.sv]
`default_nettype none
// Serial port clock setup: one request in, one result out, one at a time.
// Master requests run the half-divisor division, up to three shifts and a
// setup step, then up to 126 candidate divisions on one shared radix-2
// divider. Slave and zero-baud requests skip the divisions. The result
// is held until taken; the next request is accepted after that.
module serial_port_clock_and_control_setup #(
  parameter int unsigned MAX_HALF_PRESCALE = spcs_pkg::MAX_HALF_PRESCALE,
  parameter int unsigned MAX_SERIAL_RATE = spcs_pkg::MAX_SERIAL_RATE
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // core_clock_hz[31:0], baud_hz[63:32], frame_protocol[65:64],
  // frame_bits[70:66], clock_idle_high[71], capture_falling[72],
  // loop_back[73], port_mode[75:74]
  input  wire logic [79:0] s_tdata,
  output logic m_tvalid,
  input  wire logic m_tready,
  // control_word0[15:0], control_word1[19:16], prescale_word[27:20],
  // pclk_select_code[29:28], pclk_divide_log[31:30], clock_error[32]
  output logic [39:0] m_tdata
);
  spcs_pkg::cmd_t cmd;
  spcs_pkg::status_t status;
  logic busy, done, in_beat, out_beat;
  logic [15:0] cw0;
  logic [3:0] cw1;
  logic [7:0] pre;
  logic [1:0] psel, plog;
  logic cerr;

  assign s_tready = !busy;
  assign in_beat = s_tvalid && s_tready;
  assign m_tvalid = done;
  assign out_beat = m_tvalid && m_tready;
  assign m_tdata = {7'b0, cerr, plog, psel, pre, cw1, cw0};

  spcs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_beat(in_beat), .out_beat(out_beat),
    .status(status), .cmd(cmd), .busy(busy), .done(done)
  );

  spcs_datapath #(
    .MAX_HALF_PRESCALE(MAX_HALF_PRESCALE), .MAX_SERIAL_RATE(MAX_SERIAL_RATE)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .core_clock_hz(s_tdata[31:0]), .baud_hz(s_tdata[63:32]),
    .frame_protocol(s_tdata[65:64]), .frame_bits(s_tdata[70:66]),
    .clock_idle_high(s_tdata[71]), .capture_falling(s_tdata[72]),
    .loop_back(s_tdata[73]), .port_mode(s_tdata[75:74]),
    .control_word0(cw0), .control_word1(cw1), .prescale_word(pre),
    .pclk_select_code(psel), .pclk_divide_log(plog), .clock_error(cerr)
  );
endmodule
`default_nettype wire
